// ===== hdl/loc_pkg.sv =====
// ----------------------------------------------------------------------------
// loc_pkg
// Shared widths, codes and types of the lock order checker.
// ----------------------------------------------------------------------------
package loc_pkg;

   localparam int MAX_HELD       = 16;
   localparam int CLASS_W        = 32;
   localparam int ACTION_W       = 2;
   localparam int STATUS_W       = 3;
   localparam int HELD_DEPTH_W   = 5;
   localparam int VIOL_W         = 32;
   localparam int DEPTH_W        = $clog2(MAX_HELD + 1);

   localparam logic [ACTION_W-1:0] ACT_ACQUIRE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_QUERY   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_DEADLOCK = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 3'd4;

   typedef struct packed {
      logic push;
      logic pop;
   } shift_type;

endpackage

// ===== hdl/lock_order_checker_top.sv =====
// ----------------------------------------------------------------------------
// lock_order_checker_top
// Checks lock acquire, release and query items against a stack of held lock
// classes kept in a chain of cells, top of stack in the first cell. In the
// accept cycle every cell compares its entry with the class, and in the next
// cycle the matches are combined, the chain shifts once for a push or pop and
// the result is registered. One item is in work at a time; a new item is
// taken in the cycle its result leaves or after.
// ----------------------------------------------------------------------------
module lock_order_checker_top
   import loc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [ACTION_W-1:0]     req_action,
   input  logic [CLASS_W-1:0]      req_lock_class,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic                    rsp_is_held,
   output logic [HELD_DEPTH_W-1:0] rsp_held_depth,
   output logic [VIOL_W-1:0]       rsp_violations
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EVAL = 1'b1;

   logic                state_ff, state_in;
   logic [ACTION_W-1:0] action_ff;
   logic [CLASS_W-1:0]  class_ff;
   logic                zero_ff;
   logic                lt_ff;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic [VIOL_W-1:0]   viol_ff, viol_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic                    held_ff, held_in;

   shift_type           ctrl;
   logic [CLASS_W-1:0]  cell_data [MAX_HELD];
   logic [MAX_HELD-1:0] cell_valid;
   logic [MAX_HELD-1:0] cell_hit;
   logic                accept;
   logic                any_hit;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign any_hit   = |cell_hit;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_HELD; gi++) begin : g_cell
         logic [CLASS_W-1:0] prev_data, next_data;
         logic               prev_valid, next_valid;
         if (gi == 0) begin : g_first
            assign prev_data  = class_ff;
            assign prev_valid = 1'b1;
         end else begin : g_mid
            assign prev_data  = cell_data[gi-1];
            assign prev_valid = cell_valid[gi-1];
         end
         if (gi == MAX_HELD - 1) begin : g_last
            assign next_data  = '0;
            assign next_valid = 1'b0;
         end else begin : g_inner
            assign next_data  = cell_data[gi+1];
            assign next_valid = cell_valid[gi+1];
         end
         loc_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .prev_data  (prev_data),
            .prev_valid (prev_valid),
            .next_data  (next_data),
            .next_valid (next_valid),
            .cmp_class  (req_lock_class),
            .data       (cell_data[gi]),
            .valid      (cell_valid[gi]),
            .hit        (cell_hit[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      depth_in     = depth_ff;
      viol_in      = viol_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      held_in      = held_ff;
      ctrl         = '0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            held_in      = 1'b0;
            status_in    = STATUS_OK;
            unique case (action_ff)
               ACT_ACQUIRE: begin
                  priority if (zero_ff) begin
                     status_in = STATUS_INVALID;
                  end else if (cell_valid[MAX_HELD-1]) begin
                     status_in = STATUS_OVERFLOW;
                     viol_in   = viol_ff + 1'b1;
                  end else if (any_hit || (cell_valid[0] && lt_ff)) begin
                     status_in = STATUS_DEADLOCK;
                     viol_in   = viol_ff + 1'b1;
                  end else begin
                     ctrl.push = 1'b1;
                     depth_in  = depth_ff + 1'b1;
                  end
               end
               ACT_RELEASE: begin
                  priority if (zero_ff) begin
                     status_in = STATUS_INVALID;
                  end else if (!cell_valid[0]) begin
                     status_in = STATUS_EMPTY;
                     viol_in   = viol_ff + 1'b1;
                  end else if (!cell_hit[0]) begin
                     status_in = STATUS_DEADLOCK;
                     viol_in   = viol_ff + 1'b1;
                  end else begin
                     ctrl.pop = 1'b1;
                     depth_in = depth_ff - 1'b1;
                  end
               end
               ACT_QUERY: begin
                  held_in = !zero_ff && any_hit;
               end
               default: begin
                  status_in = STATUS_INVALID;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         depth_ff     <= '0;
         viol_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         viol_ff      <= viol_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff <= status_in;
      held_ff   <= held_in;
      if (accept) begin
         action_ff <= req_action;
         class_ff  <= req_lock_class;
         zero_ff   <= (req_lock_class == '0);
         lt_ff     <= (req_lock_class < cell_data[0]);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_is_held    = held_ff;
   assign rsp_held_depth = HELD_DEPTH_W'(depth_ff);
   assign rsp_violations = viol_ff;

endmodule

// ===== hdl/loc_cell.sv =====
// ----------------------------------------------------------------------------
// loc_cell
// One stack entry of the held-lock chain: shifts toward the bottom on push,
// toward the top on pop, and flags a match against the incoming class.
// ----------------------------------------------------------------------------
module loc_cell
   import loc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  shift_type          ctrl,
   input  logic [CLASS_W-1:0] prev_data,
   input  logic               prev_valid,
   input  logic [CLASS_W-1:0] next_data,
   input  logic               next_valid,
   input  logic [CLASS_W-1:0] cmp_class,
   output logic [CLASS_W-1:0] data,
   output logic               valid,
   output logic               hit
);

   logic [CLASS_W-1:0] data_ff, data_in;
   logic               valid_ff, valid_in;
   logic               hit_ff, hit_in;

   always_comb begin
      priority if (ctrl.push) begin
         data_in  = prev_data;
         valid_in = prev_valid;
      end else if (ctrl.pop) begin
         data_in  = next_data;
         valid_in = next_valid;
      end else begin
         data_in  = data_ff;
         valid_in = valid_ff;
      end
      hit_in = valid_ff && (data_ff == cmp_class);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
      end
      data_ff <= data_in;
   end

   assign data  = data_ff;
   assign valid = valid_ff;
   assign hit   = hit_ff;

endmodule

// ===== hdl/loc_checker.sv =====
// ----------------------------------------------------------------------------
// loc_checker
// Port-level checks of the lock order checker, bound to the top level.
// ----------------------------------------------------------------------------
module loc_checker
   import loc_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [STATUS_W-1:0]     rsp_status,
   input logic                    rsp_is_held,
   input logic [HELD_DEPTH_W-1:0] rsp_held_depth,
   input logic [VIOL_W-1:0]       rsp_violations
);

   // result shows once its item has passed the evaluate state
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> ##1 rsp_valid)
      else $error("result did not follow item");

   // one item in work at a time
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item taken while another is in work");

   // held flag only on an ok result; only a query raises it
   a_held_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_held) |-> (rsp_status == STATUS_OK))
      else $error("held flag on a non-ok result");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_held_depth)
          && $stable(rsp_violations)))
      else $error("stalled result changed");

endmodule

bind lock_order_checker_top loc_checker u_loc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_is_held    (rsp_is_held),
   .rsp_held_depth (rsp_held_depth),
   .rsp_violations (rsp_violations)
);
